// File: rtl/rau_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rau_pkg
// Shared widths, operation codes and the word types passed between the
// front end, the queue and the back end of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

	localparam int OPERAND_BITS = 16;
	localparam int NUM_OUT_BITS = 2 * OPERAND_BITS + 1;
	localparam int DEN_OUT_BITS = 2 * OPERAND_BITS - 1;
	localparam int MAG_BITS     = 2 * OPERAND_BITS + 1;
	localparam int CNT_BITS     = $clog2(MAG_BITS + 1);
	localparam int IN_BITS      = 2 + 4 * OPERAND_BITS;
	localparam int IN_BYTES     = (IN_BITS + 7) / 8;
	localparam int OUT_BITS     = NUM_OUT_BITS + DEN_OUT_BITS + 1;
	localparam int OUT_BYTES    = (OUT_BITS + 7) / 8;
	localparam int QDEPTH       = 2;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	// classified job from the front end
	typedef struct packed {
		logic                    bad;
		logic                    neg;
		logic [MAG_BITS-1:0]     nm;
		logic [MAG_BITS-1:0]     dm;
	} job_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_GCD,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

// File: rtl/rau_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rau_front
// Accepts an input word, forms the unreduced numerator and denominator in
// two stages (products, then cross sum) and hands a magnitude job onward.
// ----------------------------------------------------------------------------
module rau_front (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [1:0]                        action,
	input  wire logic signed [rau_pkg::OPERAND_BITS-1:0] num_a,
	input  wire logic signed [rau_pkg::OPERAND_BITS-1:0] den_a,
	input  wire logic signed [rau_pkg::OPERAND_BITS-1:0] num_b,
	input  wire logic signed [rau_pkg::OPERAND_BITS-1:0] den_b,
	output logic                                   job_valid,
	input  wire logic                              job_ready,
	output rau_pkg::job_t                          job
);
	localparam int P = 2 * rau_pkg::OPERAND_BITS;

	logic               v_s1, v_s2;
	logic               bad_s1, sub_s1, sum_s1;
	logic signed [P-1:0] p0_s1, p1_s1, d_s1;
	rau_pkg::job_t      job_s2;
	logic signed [P:0]  n_c;
	logic [rau_pkg::MAG_BITS-1:0] nm_c, dm_c;
	logic               adv2, adv1;
	rau_pkg::op_t       op;

	assign op = rau_pkg::op_t'(action);
	assign adv2 = !v_s2 || job_ready;
	assign adv1 = !v_s1 || adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			bad_s1 <= (den_a == '0) || (den_b == '0) || (op == rau_pkg::OP_DIV && num_b == '0);
			sub_s1 <= (op == rau_pkg::OP_SUB);
			sum_s1 <= (op == rau_pkg::OP_ADD) || (op == rau_pkg::OP_SUB);
			p0_s1  <= num_a * ((op == rau_pkg::OP_MUL) ? num_b : den_b);
			p1_s1  <= num_b * den_a;
			d_s1   <= den_a * ((op == rau_pkg::OP_DIV) ? num_b : den_b);
		end
	end

	always_comb begin
		if (!sum_s1)
			n_c = {p0_s1[P-1], p0_s1};
		else if (sub_s1)
			n_c = {p0_s1[P-1], p0_s1} - {p1_s1[P-1], p1_s1};
		else
			n_c = {p0_s1[P-1], p0_s1} + {p1_s1[P-1], p1_s1};
		nm_c = n_c[P] ? rau_pkg::MAG_BITS'(-n_c) : rau_pkg::MAG_BITS'(n_c);
		dm_c = d_s1[P-1] ? rau_pkg::MAG_BITS'(-{d_s1[P-1], d_s1})
		                 : rau_pkg::MAG_BITS'({d_s1[P-1], d_s1});
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			job_s2.bad <= bad_s1;
			job_s2.neg <= (n_c != '0) && (n_c[P] != d_s1[P-1]);
			job_s2.nm  <= nm_c;
			job_s2.dm  <= dm_c;
		end
	end

	assign job_valid = v_s2;
	assign job = job_s2;
endmodule
`default_nettype wire

// File: rtl/rau_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rau_queue
// Short job queue between the front and the back end.
// ----------------------------------------------------------------------------
module rau_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_valid,
	output logic               wr_ready,
	input  wire rau_pkg::job_t wr_data,
	output logic               rd_valid,
	input  wire logic          rd_ready,
	output rau_pkg::job_t      rd_data
);
	localparam int AW = $clog2(rau_pkg::QDEPTH);

	rau_pkg::job_t  mem_q [rau_pkg::QDEPTH];
	logic [AW-1:0]  wp_q, rp_q;
	logic [AW:0]    cnt_q;
	logic           wr, rd;

	assign wr_ready = (cnt_q != (AW+1)'(rau_pkg::QDEPTH));
	assign rd_valid = (cnt_q != '0);
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end
endmodule
`default_nettype wire

// File: rtl/rau_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rau_back
// Reduces a job: binary GCD one step a cycle, then two restoring divisions
// one quotient bit a cycle, holds the result until taken; bad jobs only hold.
// ----------------------------------------------------------------------------
module rau_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          job_valid,
	output logic               job_ready,
	input  wire rau_pkg::job_t job,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic signed [rau_pkg::NUM_OUT_BITS-1:0] num_out,
	output logic [rau_pkg::DEN_OUT_BITS-1:0]        den_out,
	output logic               bad_denominator
);
	localparam int M = rau_pkg::MAG_BITS;

	rau_pkg::state_t state_q, state_d;
	logic [M-1:0] nm_q, dm_q, ga_q, gb_q, g_q, rn_q, rd_q, qn_q, qd_q;
	logic [rau_pkg::CNT_BITS-1:0] sh_q, cnt_q;
	logic neg_q, bad_q;
	logic [M:0] tn, td;
	logic gcd_end, div_end;

	assign gcd_end = (gb_q == '0);
	assign div_end = (cnt_q == '0);
	assign tn = {rn_q, qn_q[M-1]} - {1'b0, g_q};
	assign td = {rd_q, qd_q[M-1]} - {1'b0, g_q};

	always_comb begin
		state_d = state_q;
		case (state_q)
			rau_pkg::ST_IDLE: if (job_valid) state_d = job.bad ? rau_pkg::ST_DONE : rau_pkg::ST_GCD;
			rau_pkg::ST_GCD:  if (gcd_end) state_d = rau_pkg::ST_DIV;
			rau_pkg::ST_DIV:  if (div_end) state_d = rau_pkg::ST_DONE;
			rau_pkg::ST_DONE: if (out_ready) state_d = rau_pkg::ST_IDLE;
			default:          state_d = rau_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		job_ready = (state_q == rau_pkg::ST_IDLE);
		out_valid = (state_q == rau_pkg::ST_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= rau_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			rau_pkg::ST_IDLE: begin
				bad_q <= job.bad;
				neg_q <= job.neg;
				nm_q  <= job.nm;
				dm_q  <= job.dm;
				ga_q  <= job.nm;
				gb_q  <= job.dm;
				sh_q  <= '0;
			end
			rau_pkg::ST_GCD: begin
				// zero numerator: gcd is the denominator itself
				if (ga_q == '0) begin
					ga_q <= gb_q;
					gb_q <= '0;
				end else if (!ga_q[0] && !gb_q[0]) begin
					ga_q <= ga_q >> 1;
					gb_q <= gb_q >> 1;
					sh_q <= sh_q + 1'b1;
				end else if (!ga_q[0]) begin
					ga_q <= ga_q >> 1;
				end else if (!gb_q[0]) begin
					gb_q <= gb_q >> 1;
				end else if (ga_q > gb_q) begin
					ga_q <= (ga_q - gb_q) >> 1;
				end else begin
					gb_q <= (gb_q - ga_q) >> 1;
				end
				if (gcd_end) begin
					g_q   <= ga_q << sh_q;
					qn_q  <= nm_q;
					qd_q  <= dm_q;
					rn_q  <= '0;
					rd_q  <= '0;
					cnt_q <= rau_pkg::CNT_BITS'(M);
				end
			end
			rau_pkg::ST_DIV: begin
				if (!div_end) begin
					cnt_q <= cnt_q - 1'b1;
					if (!tn[M]) begin
						rn_q <= tn[M-1:0];
						qn_q <= {qn_q[M-2:0], 1'b1};
					end else begin
						rn_q <= {rn_q[M-2:0], qn_q[M-1]};
						qn_q <= {qn_q[M-2:0], 1'b0};
					end
					if (!td[M]) begin
						rd_q <= td[M-1:0];
						qd_q <= {qd_q[M-2:0], 1'b1};
					end else begin
						rd_q <= {rd_q[M-2:0], qd_q[M-1]};
						qd_q <= {qd_q[M-2:0], 1'b0};
					end
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		if (bad_q) begin
			num_out = '0;
			den_out = '0;
		end else begin
			num_out = neg_q ? rau_pkg::NUM_OUT_BITS'(-qn_q) : rau_pkg::NUM_OUT_BITS'(qn_q);
			den_out = qd_q[rau_pkg::DEN_OUT_BITS-1:0];
		end
		bad_denominator = bad_q;
	end
endmodule
`default_nettype wire

// File: rtl/rational_arithmetic_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Adds, subtracts, multiplies or divides two fractions, reduced to lowest
// terms with a positive denominator.
// ----------------------------------------------------------------------------
// Items are handled one at a time in the back end. A word passes the two
// front-end stages and the queue. The back end then takes the job, runs the
// binary GCD steps and a closing step, the division steps and a closing step,
// and shows the result until it is taken. The GCD loop, whose length depends
// on the operands, sets the spread in time per job. The two divisions run
// side by side. A two-entry queue lets the front end take new words while the
// back end works. Error words (zero denominator or divisor) skip the loop and
// return 0/0 with bad_denominator set.
module rational_arithmetic_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	// action[1:0], num_a, den_a, num_b, den_b from bit 0 up, zero padded
	input  wire logic [8*rau_pkg::IN_BYTES-1:0]  s_tdata,
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	// num_out, den_out, bad_denominator from bit 0 up, zero padded
	output logic [8*rau_pkg::OUT_BYTES-1:0] m_tdata
);
	localparam int W = rau_pkg::OPERAND_BITS;

	logic          jv, jr, qv, qr;
	rau_pkg::job_t jf, jq;
	logic signed [rau_pkg::NUM_OUT_BITS-1:0] num_out;
	logic [rau_pkg::DEN_OUT_BITS-1:0]        den_out;
	logic          bad;

	rau_front u_front (
		.clk, .arst_n,
		.in_valid(s_tvalid), .in_ready(s_tready),
		.action(s_tdata[1:0]),
		.num_a(s_tdata[2+W-1:2]),
		.den_a(s_tdata[2+2*W-1:2+W]),
		.num_b(s_tdata[2+3*W-1:2+2*W]),
		.den_b(s_tdata[2+4*W-1:2+3*W]),
		.job_valid(jv), .job_ready(jr), .job(jf)
	);

	rau_queue u_queue (
		.clk, .arst_n,
		.wr_valid(jv), .wr_ready(jr), .wr_data(jf),
		.rd_valid(qv), .rd_ready(qr), .rd_data(jq)
	);

	rau_back u_back (
		.clk, .arst_n,
		.job_valid(qv), .job_ready(qr), .job(jq),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.num_out, .den_out, .bad_denominator(bad)
	);

	assign m_tdata = (8*rau_pkg::OUT_BYTES)'({bad, den_out, num_out});
endmodule
`default_nettype wire

// File: rtl/rau_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rau_checker
// Port-level checks for the rational arithmetic unit.
// ----------------------------------------------------------------------------
module rau_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            m_tvalid,
	input wire logic                            m_tready,
	input wire logic [8*rau_pkg::OUT_BYTES-1:0] m_tdata
);
	localparam int NB = rau_pkg::NUM_OUT_BITS;
	localparam int DB = rau_pkg::DEN_OUT_BITS;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[NB+DB] |-> m_tdata[NB+DB-1:0] == '0)
		else $error("error word carries data");

	a_den: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[NB+DB] |-> m_tdata[NB+DB-1:NB] != '0)
		else $error("zero denominator on good word");

	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready |=> !m_tvalid)
		else $error("back-to-back results");
endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
	.clk, .arst_n, .m_tvalid, .m_tready, .m_tdata
);
`default_nettype wire

// File: tb/tb_rational_arithmetic_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rational_arithmetic_unit
// Streams fraction pairs and operations into the unit with random gaps and
// output stalls, and compares every result word with a reduced fraction
// computed independently in the testbench.
// ----------------------------------------------------------------------------
module tb_rational_arithmetic_unit;
	import rau_pkg::*;

	// packed from the top bit down: bad_denominator, den_out, num_out
	typedef struct packed {
		logic                    bad;
		logic [DEN_OUT_BITS-1:0] den;
		logic [NUM_OUT_BITS-1:0] num;
	} frac_t;

	class fraction_board;
		frac_t pending[$];
		int    errors;

		function longint unsigned gcd64(longint unsigned x, longint unsigned y);
			longint unsigned t;
			while (y != 0) begin
				t = x % y;
				x = y;
				y = t;
			end
			return x;
		endfunction

		function void note_operands(op_t op, logic signed [15:0] na, logic signed [15:0] da,
				logic signed [15:0] nb, logic signed [15:0] db);
			longint n, d;
			longint unsigned nm, dm, g;
			frac_t r;
			r = '0;
			if (da == 0 || db == 0 || (op == OP_DIV && nb == 0)) begin
				r.bad = 1'b1;
			end else begin
				case (op)
					OP_ADD: begin n = na * db + nb * da; d = longint'(da) * db; end
					OP_SUB: begin n = na * db - nb * da; d = longint'(da) * db; end
					OP_MUL: begin n = longint'(na) * nb; d = longint'(da) * db; end
					default: begin n = longint'(na) * db; d = longint'(da) * nb; end
				endcase
				nm = n < 0 ? -n : n;
				dm = d < 0 ? -d : d;
				g = gcd64(nm, dm);
				nm = nm / g;
				dm = dm / g;
				if (nm != 0 && ((n < 0) != (d < 0))) nm = -nm;
				r.num = nm[NUM_OUT_BITS-1:0];
				r.den = dm[DEN_OUT_BITS-1:0];
			end
			pending.push_back(r);
		endfunction

		function void check_result(frac_t got);
			frac_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.num !== want.num) begin
				$display("%0t: num_out expected %0d actual %0d", $time,
					$signed(want.num), $signed(got.num));
				errors++;
			end
			if (got.den !== want.den) begin
				$display("%0t: den_out expected %0d actual %0d", $time, want.den, got.den);
				errors++;
			end
			if (got.bad !== want.bad) begin
				$display("%0t: bad_denominator expected %b actual %b", $time, want.bad, got.bad);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// action, num_a, den_a, num_b, den_b from bit 0 up, zero padded
	logic [8*IN_BYTES-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// num_out, den_out, bad_denominator from bit 0 up, zero padded
	logic [8*OUT_BYTES-1:0] m_tdata;

	fraction_board board = new();
	bit sending_done = 1'b0;
	bit calm = 1'b0;

	rational_arithmetic_unit dut (.*);

	always #5 clk = ~clk;

	function automatic logic [15:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'(int'($urandom_range(0, 6)) - 3);
			4, 5: return 16'(int'($urandom_range(0, 40)) - 20);
			default: return 16'($urandom);
		endcase
	endfunction

	// valid stays high between words unless a gap is drawn
	task automatic send_word(op_t op, logic [15:0] na, logic [15:0] da, logic [15:0] nb,
			logic [15:0] db);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 19);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata <= {db, nb, da, na, op};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.note_operands(op, na, da, nb, db);
		@(negedge clk);
	endtask

	// result side: random stalls per word
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = calm ? 0 : $urandom_range(0, 19);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			board.check_result(m_tdata[OUT_BITS-1:0]);
		end
	end

	initial begin
		logic [15:0] edges[6] = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001, 16'hffff, 16'h0006};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// directed: every operation on extremes, zero denominators, divide by zero
		for (int o = 0; o < 4; o++) begin
			send_word(op_t'(o), 16'h8000, 16'h7fff, 16'h8000, 16'h0001);
			send_word(op_t'(o), 16'h7fff, 16'h8000, 16'h7fff, 16'hffff);
			send_word(op_t'(o), 16'h0000, 16'h0003, 16'h0005, 16'hfff9);
			send_word(op_t'(o), 16'h0004, 16'h0000, 16'h0002, 16'h0003);
			send_word(op_t'(o), 16'h0006, 16'hfffc, 16'h0000, 16'h0000);
		end
		send_word(OP_DIV, 16'h0003, 16'h0005, 16'h0000, 16'h0007);
		send_word(OP_SUB, 16'h0002, 16'h0004, 16'h0001, 16'h0002);
		for (int i = 0; i < 1450; i++) begin
			calm = (i / 100) % 4 == 3;
			if ($urandom_range(0, 7) == 0)
				send_word(op_t'($urandom_range(0, 3)), edges[$urandom_range(0, 5)],
					edges[$urandom_range(0, 5)], edges[$urandom_range(0, 5)],
					edges[$urandom_range(0, 5)]);
			else
				send_word(op_t'($urandom_range(0, 3)), pick_operand(), pick_operand(),
					pick_operand(), pick_operand());
		end
		s_tvalid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (board.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("Verification failed");
		$finish;
	end

endmodule

// File: sim.f
rtl/rau_pkg.sv
rtl/rau_front.sv
rtl/rau_queue.sv
rtl/rau_back.sv
rtl/rational_arithmetic_unit.sv
rtl/rau_checker.sv
tb/tb_rational_arithmetic_unit.sv
